FILE: src/char_lcd_nibble_writer_assert.svh
// assertion macros shared by the character lcd nibble writer modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// same-cycle implication
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/clcd_pkg.sv
// types, constants and tables for the character lcd nibble writer
// no dependencies
package clcd_pkg;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_DATA     = 3'd1,
        MODE_CURSOR   = 3'd2,
        MODE_CLEAR    = 3'd3,
        MODE_DISP_ON  = 3'd4,
        MODE_DISP_OFF = 3'd5,
        MODE_GLYPH    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_LONG,
        EXTRA_SHORT,
        EXTRA_CLEAR
    } t_extra;

    localparam logic [2:0] REG_SETTLE     = 3'd0;
    localparam logic [2:0] REG_CLEAR_WAIT = 3'd1;
    localparam logic [2:0] REG_POWER_UP   = 3'd2;
    localparam logic [2:0] REG_ROWS       = 3'd3;
    localparam logic [2:0] REG_COLS       = 3'd4;

    localparam logic [15:0] SETTLE_RST     = 16'd100;
    localparam logic [15:0] CLEAR_WAIT_RST = 16'd2000;
    localparam logic [19:0] POWER_UP_RST   = 20'd50000;
    localparam logic [2:0]  ROWS_RST       = 3'd2;
    localparam logic [4:0]  COLS_RST       = 5'd16;

    localparam logic [2:0]  ROWS_MAX = 3'd4;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_DISP_OFF = 8'h08;
    localparam logic [7:0] CMD_CGRAM    = 8'h40;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;

    localparam logic [15:0] WAIT_LONG_US  = 16'd5000;
    localparam logic [15:0] WAIT_SHORT_US = 16'd500;

    localparam logic [3:0] INIT_LAST = 4'd15;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
        logic       clear_extra;
    } t_cmd;

    typedef struct packed {
        logic [15:0] settle_us;
        logic [15:0] clear_wait_us;
        logic [19:0] power_up_us;
    } t_timing;

    typedef struct packed {
        logic [2:0] rows;
        logic [4:0] cols;
    } t_geom;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [19:0] pre_wait_us;
        logic [16:0] post_wait_us;
        logic        last;
    } t_result;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h03;
            3'd3:             b = 8'h02;
            3'd4:             b = 8'h28;
            3'd5:             b = 8'h08;
            3'd6:             b = 8'h01;
            default:          b = 8'h06;
        endcase
        return b;
    endfunction

    function automatic t_extra init_extra(input logic [2:0] idx);
        t_extra e;
        case (idx)
            3'd0, 3'd1: e = EXTRA_LONG;
            3'd2:       e = EXTRA_SHORT;
            3'd6:       e = EXTRA_CLEAR;
            default:    e = EXTRA_NONE;
        endcase
        return e;
    endfunction

    function automatic logic [6:0] row_base(input logic [1:0] idx);
        logic [6:0] b;
        case (idx)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            default: b = 7'h54;
        endcase
        return b;
    endfunction

endpackage

FILE: src/clcd_front.sv
// front end: takes requests and turns each one of a known mode into one queued command
// depends on clcd_pkg
module clcd_front import clcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_value,
    input  logic [7:0] i_row,
    input  logic [7:0] i_column,
    input  t_geom      i_geom,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_data
);

    logic       accept;
    logic       known;
    logic [2:0] rlim;
    logic [2:0] row_c;
    logic [4:0] col_c;
    logic [1:0] row_idx;
    logic [6:0] addr;

    assign accept = i_push && !i_q_full;

    always_comb begin
        if (i_geom.rows > ROWS_MAX) begin
            rlim = ROWS_MAX;
        end else if (i_geom.rows == 3'd0) begin
            rlim = 3'd1;
        end else begin
            rlim = i_geom.rows;
        end
        if (i_row > {5'd0, rlim}) begin
            row_c = rlim;
        end else if (i_row == 8'd0) begin
            row_c = 3'd1;
        end else begin
            row_c = i_row[2:0];
        end
        if (i_column > {3'd0, i_geom.cols}) begin
            col_c = i_geom.cols;
        end else begin
            col_c = i_column[4:0];
        end
        if (col_c == 5'd0) begin
            col_c = 5'd1;
        end
        row_idx = 2'(row_c - 3'd1);
        addr    = 7'(row_base(row_idx) + {2'd0, col_c} - 7'd1);
    end

    always_comb begin
        known    = 1'b1;
        o_q_data = '{is_init: 1'b0, rs: 1'b0, data: 8'h00, clear_extra: 1'b0};
        case (i_mode)
            MODE_INIT: begin
                o_q_data.is_init = 1'b1;
            end
            MODE_DATA: begin
                o_q_data.rs   = 1'b1;
                o_q_data.data = i_value;
            end
            MODE_CURSOR: begin
                o_q_data.data = CMD_DDRAM | {1'b0, addr};
            end
            MODE_CLEAR: begin
                o_q_data.data        = CMD_CLEAR;
                o_q_data.clear_extra = 1'b1;
            end
            MODE_DISP_ON: begin
                o_q_data.data = CMD_DISP_ON;
            end
            MODE_DISP_OFF: begin
                o_q_data.data = CMD_DISP_OFF;
            end
            MODE_GLYPH: begin
                o_q_data.data = CMD_CGRAM | {2'b00, i_value[2:0], 3'b000};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && known;

    `include "char_lcd_nibble_writer_assert.svh"

    `CLCD_ASSERT_IMP(a_no_push_when_full, i_q_full, !o_q_push, "push into full command queue")
    `CLCD_ASSERT_IMP(a_cursor_is_ddram, o_q_push && (i_mode == MODE_CURSOR), o_q_data.data[7], "cursor command lost address flag")

endmodule

FILE: src/clcd_cmd_q.sv
// short command queue between the front and back ends
// depends on clcd_pkg
module clcd_cmd_q import clcd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : PW'(r_wptr + 1'b1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : PW'(r_rptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `include "char_lcd_nibble_writer_assert.svh"

    `CLCD_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_FULL, "command queue count overflow")

endmodule

FILE: src/clcd_back.sv
// back end: expands queued commands into nibble strobes, one per cycle while its output register is not stalled
// depends on clcd_pkg
module clcd_back import clcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_timing i_timing,
    input  logic    i_q_valid,
    input  t_cmd    i_q_data,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_cmd        r_cur;
    logic        r_active;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    t_result     r_out;
    logic        n_active;
    logic [3:0]  n_idx;
    logic        adv;
    logic        cur_last;
    logic        load;
    logic [7:0]  cur_byte;
    logic [15:0] extra;
    t_result     nib_res;

    assign adv      = !r_out_valid || i_pop;
    assign cur_last = r_cur.is_init ? (r_idx == INIT_LAST) : r_idx[0];
    assign load     = !r_active || (adv && cur_last);
    assign o_q_pop  = load && i_q_valid;

    always_comb begin
        cur_byte = r_cur.is_init ? init_byte(r_idx[3:1]) : r_cur.data;
        extra    = 16'd0;
        if (r_idx[0]) begin
            if (r_cur.is_init) begin
                case (init_extra(r_idx[3:1]))
                    EXTRA_LONG:  extra = WAIT_LONG_US;
                    EXTRA_SHORT: extra = WAIT_SHORT_US;
                    EXTRA_CLEAR: extra = i_timing.clear_wait_us;
                    default:     extra = 16'd0;
                endcase
            end else if (r_cur.clear_extra) begin
                extra = i_timing.clear_wait_us;
            end
        end
        nib_res.reg_select   = r_cur.rs;
        nib_res.nibble       = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
        nib_res.pre_wait_us  = (r_cur.is_init && (r_idx == 4'd0)) ? i_timing.power_up_us
                                                                   : 20'd0;
        nib_res.post_wait_us = {1'b0, i_timing.settle_us} + {1'b0, extra};
        nib_res.last         = cur_last;
    end

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (load) begin
            n_active = i_q_valid;
            n_idx    = 4'd0;
        end else if (adv) begin
            n_idx = 4'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            if (adv) begin
                r_out_valid <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        if (adv && r_active) begin
            r_out <= nib_res;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `include "char_lcd_nibble_writer_assert.svh"

    `CLCD_ASSERT_IMP(a_byte_two_nibbles, r_active && !r_cur.is_init, r_idx[3:1] == 3'd0, "byte command ran past two nibbles")
    `CLCD_ASSERT_NXT(a_emit_fills_out, adv && r_active, r_out_valid, "emitted nibble not in output register")
    `CLCD_ASSERT_NXT(a_idle_after_last, r_active && adv && cur_last && !i_q_valid, !r_active, "back end still busy after last nibble")

endmodule

FILE: src/char_lcd_nibble_writer.sv
// Character LCD 4-bit bus writer. Each accepted request (data byte, set cursor, clear,
// display on/off, glyph slot) yields two nibble transactions, high nibble first; an init
// request yields sixteen. Each result carries register select, the nibble, the wait before
// the strobe and the total wait after it. The back end emits one nibble per cycle while
// its output is not stalled; requests enter at one per cycle until the command queue
// (CMD_DEPTH entries) fills. A result passes the queue, the command and output registers.
// top level; depends on clcd_pkg, clcd_front, clcd_cmd_q, clcd_back
module char_lcd_nibble_writer import clcd_pkg::*; #(
    parameter int CMD_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_value,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_column,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic [19:0] o_pre_wait_us,
    output logic [16:0] o_post_wait_us,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_settle_us;
    logic [15:0] r_clear_wait_us;
    logic [19:0] r_power_up_us;
    logic [2:0]  r_rows;
    logic [4:0]  r_cols;
    logic        wr_en;
    t_timing     timing;
    t_geom       geom;
    logic        q_push;
    t_cmd        q_wdata;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_cmd        q_rdata;
    t_result     res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_us     <= SETTLE_RST;
            r_clear_wait_us <= CLEAR_WAIT_RST;
            r_power_up_us   <= POWER_UP_RST;
            r_rows          <= ROWS_RST;
            r_cols          <= COLS_RST;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_SETTLE:     r_settle_us     <= pwdata[15:0];
                REG_CLEAR_WAIT: r_clear_wait_us <= pwdata[15:0];
                REG_POWER_UP:   r_power_up_us   <= pwdata[19:0];
                REG_ROWS:       r_rows          <= pwdata[2:0];
                REG_COLS:       r_cols          <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SETTLE:     prdata = {16'd0, r_settle_us};
            REG_CLEAR_WAIT: prdata = {16'd0, r_clear_wait_us};
            REG_POWER_UP:   prdata = {12'd0, r_power_up_us};
            REG_ROWS:       prdata = {29'd0, r_rows};
            REG_COLS:       prdata = {27'd0, r_cols};
            default:        prdata = 32'd0;
        endcase
    end

    assign timing = '{settle_us: r_settle_us, clear_wait_us: r_clear_wait_us,
                      power_up_us: r_power_up_us};
    assign geom   = '{rows: r_rows, cols: r_cols};

    clcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_mode   (i_mode),
        .i_value  (i_value),
        .i_row    (i_row),
        .i_column (i_column),
        .i_geom   (geom),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    clcd_cmd_q #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    clcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timing  (timing),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (res)
    );

    assign o_full         = q_full;
    assign o_reg_select   = res.reg_select;
    assign o_nibble       = res.nibble;
    assign o_pre_wait_us  = res.pre_wait_us;
    assign o_post_wait_us = res.post_wait_us;
    assign o_last         = res.last;

endmodule
